@@ rtl/lik_pkg.sv @@
// shared types, constants and tables for the leg inverse kinematics block
package lik_pkg;

    // field widths
    localparam int LEN_W   = 15;
    localparam int POS_W   = 16;
    localparam int REST_W  = 17;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 17;

    // internal widths
    localparam int CW      = 30;   // cordic x/y
    localparam int ZW      = 26;   // angle in degrees Q.16
    localparam int SQ_W    = 52;   // square root operand
    localparam int SQ_RW   = 26;   // square root result
    localparam int MW      = 27;   // multiplier operand
    localparam int PW      = 2 * MW;
    localparam int AW      = 37;   // accumulator

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_DEPTH            = 24;

    localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(11796480);

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_UPPER_LEN  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_LOWER_LEN  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_OFFSET_X   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_OFFSET_Z   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_REST_HIP   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_REST_KNEE  = 3'd5;

    // register reset values
    localparam logic [LEN_W-1:0]         RST_UPPER_LEN = 15'd512;
    localparam logic [LEN_W-1:0]         RST_LOWER_LEN = 15'd768;
    localparam logic signed [POS_W-1:0]  RST_OFFSET_X  = -16'sd1024;
    localparam logic signed [POS_W-1:0]  RST_OFFSET_Z  = -16'sd512;
    localparam logic signed [REST_W-1:0] RST_REST_HIP  = 17'sd10392;
    localparam logic signed [REST_W-1:0] RST_REST_KNEE = -17'sd17513;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_MUL6, ST_MUL7,
        ST_MUL8, ST_MUL9, ST_MUL10, ST_SQL_GO, ST_SQL_WT, ST_SQH_GO, ST_SQH_WT,
        ST_MUL11, ST_MUL12, ST_MUL13, ST_CB_GO, ST_CB_WT, ST_CP_GO, ST_CP_WT,
        ST_AC_CHK, ST_DV_GO, ST_DV_WT, ST_AC_SQR, ST_ASQ_GO, ST_ASQ_WT,
        ST_ACD_GO, ST_ACD_WT, ST_FIN, ST_OUT
    } t_state;

    // datapath operations
    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_MUL1, OP_MUL2, OP_MUL3, OP_MUL4, OP_MUL5, OP_MUL6,
        OP_MUL7, OP_MUL8, OP_MUL9, OP_MUL10, OP_SQL_GO, OP_SQL_WT, OP_SQH_GO,
        OP_SQH_WT, OP_MUL11, OP_MUL12, OP_MUL13, OP_CB_GO, OP_CB_WT, OP_CP_GO,
        OP_CP_WT, OP_AC_CHK, OP_DV_GO, OP_DV_WT, OP_AC_SQR, OP_ASQ_GO, OP_ASQ_WT,
        OP_ACD_GO, OP_ACD_WT, OP_FIN, OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel;      // 0: theta pass, 1: gamma pass
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic need_div;
        logic out_full;
    } t_status;

    // atan(2^-i) in degrees Q.16
    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // leg frame rotation, Q1.16
    function automatic logic signed [17:0] rot_cos(input logic [2:0] leg);
        logic signed [17:0] v;
        unique case (leg)
            3'd2:    v = 18'sd65536;
            3'd3:    v = 18'sd32768;
            3'd4:    v = -18'sd32768;
            3'd5:    v = -18'sd65536;
            3'd6:    v = -18'sd32768;
            default: v = 18'sd32768;
        endcase
        return v;
    endfunction

    function automatic logic signed [17:0] rot_sin(input logic [2:0] leg);
        logic signed [17:0] v;
        unique case (leg)
            3'd2:    v = 18'sd0;
            3'd3:    v = 18'sd56755;
            3'd4:    v = 18'sd56755;
            3'd5:    v = 18'sd0;
            3'd6:    v = -18'sd56755;
            default: v = -18'sd56755;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/lik_isqrt.sv @@
// bit-serial floor square root, two operand bits per cycle
module lik_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lik_pkg::SQ_W-1:0]    i_arg,
    output logic                        o_busy,
    output logic [lik_pkg::SQ_RW-1:0]   o_root
);
    import lik_pkg::*;

    localparam int STEPS = SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [SQ_W-1:0]  r_v, r_res, r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [SQ_W-1:0]  trial;

    assign trial = r_res + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // one root bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_arg;
            r_res <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[SQ_RW-1:0];

endmodule

@@ rtl/lik_cordic.sv @@
// iterated vectoring cordic, atan2 in degrees Q.16
module lik_cordic #(
    parameter int CORDIC_ITERATIONS = lik_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [lik_pkg::CW-1:0] i_y,
    input  logic signed [lik_pkg::CW-1:0] i_x,
    output logic                          o_busy,
    output logic signed [lik_pkg::ZW-1:0] o_angle
);
    import lik_pkg::*;

    localparam int IW = $clog2(CORDIC_ITERATIONS);

    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [IW-1:0]        r_i;
    logic                 r_busy;
    logic signed [CW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] step_angle;

    assign sh_x       = r_x >>> r_i;
    assign sh_y       = r_y >>> r_i;
    assign step_angle = atan_q16(int'(r_i));

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= (i_y != '0);
            r_i    <= '0;
        end else if (r_busy) begin
            if (r_i == IW'(CORDIC_ITERATIONS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    // prerotation into the right half plane, then micro-rotations
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_y == '0) begin
                r_z <= (i_x < 0) ? DEG180_Q16 : '0;
                r_x <= i_x;
                r_y <= i_y;
            end else if (i_x < 0) begin
                r_z <= (i_y > 0) ? DEG180_Q16 : -DEG180_Q16;
                r_x <= -i_x;
                r_y <= -i_y;
            end else begin
                r_z <= '0;
                r_x <= i_x;
                r_y <= i_y;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + step_angle;
            end else begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - step_angle;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_z;

endmodule

@@ rtl/lik_ctrl.sv @@
// sequencer that steps the datapath through one leg solution
module lik_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  lik_pkg::t_status i_status,
    output lik_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);
    import lik_pkg::*;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        unique case (r_state)
            ST_IDLE: begin
                n_pass = 1'b0;
                if (i_in_valid) n_state = ST_MUL1;
            end
            ST_MUL1:   n_state = ST_MUL2;
            ST_MUL2:   n_state = ST_MUL3;
            ST_MUL3:   n_state = ST_MUL4;
            ST_MUL4:   n_state = ST_MUL5;
            ST_MUL5:   n_state = ST_MUL6;
            ST_MUL6:   n_state = ST_MUL7;
            ST_MUL7:   n_state = ST_MUL8;
            ST_MUL8:   n_state = ST_MUL9;
            ST_MUL9:   n_state = ST_MUL10;
            ST_MUL10:  n_state = ST_SQL_GO;
            ST_SQL_GO: n_state = ST_SQL_WT;
            ST_SQL_WT: if (!i_status.busy) n_state = ST_SQH_GO;
            ST_SQH_GO: n_state = ST_SQH_WT;
            ST_SQH_WT: if (!i_status.busy) n_state = ST_MUL11;
            ST_MUL11:  n_state = ST_MUL12;
            ST_MUL12:  n_state = ST_MUL13;
            ST_MUL13:  n_state = ST_CB_GO;
            ST_CB_GO:  n_state = ST_CB_WT;
            ST_CB_WT:  if (!i_status.busy) n_state = ST_CP_GO;
            ST_CP_GO:  n_state = ST_CP_WT;
            ST_CP_WT:  if (!i_status.busy) n_state = ST_AC_CHK;
            ST_AC_CHK: n_state = i_status.need_div ? ST_DV_GO : ST_AC_SQR;
            ST_DV_GO:  n_state = ST_DV_WT;
            ST_DV_WT:  if (!i_status.busy) n_state = ST_AC_SQR;
            ST_AC_SQR: n_state = ST_ASQ_GO;
            ST_ASQ_GO: n_state = ST_ASQ_WT;
            ST_ASQ_WT: if (!i_status.busy) n_state = ST_ACD_GO;
            ST_ACD_GO: n_state = ST_ACD_WT;
            ST_ACD_WT: begin
                if (!i_status.busy) begin
                    if (r_pass) begin
                        n_state = ST_FIN;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = ST_AC_CHK;
                    end
                end
            end
            ST_FIN:    n_state = ST_OUT;
            ST_OUT:    if (!i_status.out_full) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.sel  = r_pass;
        o_in_stall = (r_state != ST_IDLE) || !i_rst_n;
        unique case (r_state)
            ST_IDLE:   o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            ST_MUL1:   o_cmd.op = OP_MUL1;
            ST_MUL2:   o_cmd.op = OP_MUL2;
            ST_MUL3:   o_cmd.op = OP_MUL3;
            ST_MUL4:   o_cmd.op = OP_MUL4;
            ST_MUL5:   o_cmd.op = OP_MUL5;
            ST_MUL6:   o_cmd.op = OP_MUL6;
            ST_MUL7:   o_cmd.op = OP_MUL7;
            ST_MUL8:   o_cmd.op = OP_MUL8;
            ST_MUL9:   o_cmd.op = OP_MUL9;
            ST_MUL10:  o_cmd.op = OP_MUL10;
            ST_SQL_GO: o_cmd.op = OP_SQL_GO;
            ST_SQL_WT: o_cmd.op = OP_SQL_WT;
            ST_SQH_GO: o_cmd.op = OP_SQH_GO;
            ST_SQH_WT: o_cmd.op = OP_SQH_WT;
            ST_MUL11:  o_cmd.op = OP_MUL11;
            ST_MUL12:  o_cmd.op = OP_MUL12;
            ST_MUL13:  o_cmd.op = OP_MUL13;
            ST_CB_GO:  o_cmd.op = OP_CB_GO;
            ST_CB_WT:  o_cmd.op = OP_CB_WT;
            ST_CP_GO:  o_cmd.op = OP_CP_GO;
            ST_CP_WT:  o_cmd.op = OP_CP_WT;
            ST_AC_CHK: o_cmd.op = OP_AC_CHK;
            ST_DV_GO:  o_cmd.op = OP_DV_GO;
            ST_DV_WT:  o_cmd.op = OP_DV_WT;
            ST_AC_SQR: o_cmd.op = OP_AC_SQR;
            ST_ASQ_GO: o_cmd.op = OP_ASQ_GO;
            ST_ASQ_WT: o_cmd.op = OP_ASQ_WT;
            ST_ACD_GO: o_cmd.op = OP_ACD_GO;
            ST_ACD_WT: o_cmd.op = OP_ACD_WT;
            ST_FIN:    o_cmd.op = OP_FIN;
            ST_OUT:    o_cmd.op = i_status.out_full ? OP_NONE : OP_OUT;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/lik_dp.sv @@
// datapath: config registers, shared multiplier, divider, root and angle units
module lik_dp #(
    parameter int CORDIC_ITERATIONS = lik_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lik_pkg::t_cmd                      i_cmd,
    output lik_pkg::t_status                   o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lik_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [lik_pkg::CDAT_W-1:0]         i_cfg_data,
    input  logic signed [lik_pkg::POS_W-1:0]   i_target_x,
    input  logic signed [lik_pkg::POS_W-1:0]   i_target_y,
    input  logic signed [lik_pkg::POS_W-1:0]   i_target_z,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_leg_number,
    output logic signed [15:0]                 o_base_angle,
    output logic signed [16:0]                 o_hip_angle,
    output logic signed [16:0]                 o_knee_angle,
    output logic signed [17:0]                 o_hip_servo_angle,
    output logic signed [17:0]                 o_knee_servo_angle,
    output logic                               o_reachable
);
    import lik_pkg::*;

    // configuration registers
    logic [LEN_W-1:0]         r_upper, r_lower;
    logic signed [POS_W-1:0]  r_offx, r_offz;
    logic signed [REST_W-1:0] r_rest_hip, r_rest_knee;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= RST_UPPER_LEN;
            r_lower     <= RST_LOWER_LEN;
            r_offx      <= RST_OFFSET_X;
            r_offz      <= RST_OFFSET_Z;
            r_rest_hip  <= RST_REST_HIP;
            r_rest_knee <= RST_REST_KNEE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UPPER_LEN: r_upper     <= i_cfg_data[LEN_W-1:0];
                CFG_LOWER_LEN: r_lower     <= i_cfg_data[LEN_W-1:0];
                CFG_OFFSET_X:  r_offx      <= i_cfg_data[POS_W-1:0];
                CFG_OFFSET_Z:  r_offz      <= i_cfg_data[POS_W-1:0];
                CFG_REST_HIP:  r_rest_hip  <= i_cfg_data[REST_W-1:0];
                CFG_REST_KNEE: r_rest_knee <= i_cfg_data[REST_W-1:0];
                default: ;
            endcase
        end
    end

    // leg counter
    logic [2:0] r_cur_leg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_leg <= 3'd1;
        end else if (i_cmd.op == OP_LOAD) begin
            r_cur_leg <= (r_cur_leg == 3'd6) ? 3'd1 : r_cur_leg + 3'd1;
        end
    end

    // working registers
    logic [2:0]                r_leg;
    logic signed [POS_W-1:0]   r_x, r_y;
    logic signed [17:0]        r_c, r_s;
    logic signed [17:0]        r_xr, r_yr;
    logic signed [16:0]        r_zr;
    logic signed [PW-1:0]      r_prod;
    logic signed [AW-1:0]      r_acc;
    logic [34:0]               r_l2, r_h2;
    logic signed [35:0]        r_num1, r_num2;
    logic [40:0]               r_den1, r_den2;
    logic [SQ_RW-1:0]          r_lq, r_hq;
    logic signed [15:0]        r_base;
    logic signed [ZW-1:0]      r_phi, r_theta, r_gamma;
    logic signed [17:0]        r_r;
    logic [16:0]               r_sroot;
    logic signed [17:0]        r_hip, r_knee;
    logic                      r_ok;

    // multiplier operand selection
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL1: begin mul_a = MW'(r_x);  mul_b = MW'(r_c);  end
            OP_MUL2: begin mul_a = MW'(r_y);  mul_b = MW'(r_s);  end
            OP_MUL3: begin mul_a = MW'(r_y);  mul_b = MW'(r_c);  end
            OP_MUL4: begin mul_a = MW'(r_x);  mul_b = MW'(r_s);  end
            OP_MUL5: begin mul_a = MW'(r_xr); mul_b = MW'(r_xr); end
            OP_MUL6: begin mul_a = MW'(r_yr); mul_b = MW'(r_yr); end
            OP_MUL7: begin mul_a = MW'(r_zr); mul_b = MW'(r_zr); end
            OP_MUL8: begin
                mul_a = $signed({{(MW-LEN_W){1'b0}}, r_upper});
                mul_b = $signed({{(MW-LEN_W){1'b0}}, r_upper});
            end
            OP_MUL9: begin
                mul_a = $signed({{(MW-LEN_W){1'b0}}, r_lower});
                mul_b = $signed({{(MW-LEN_W){1'b0}}, r_lower});
            end
            OP_MUL11: begin
                mul_a = $signed({{(MW-LEN_W){1'b0}}, r_upper});
                mul_b = $signed({{(MW-SQ_RW){1'b0}}, r_hq});
            end
            OP_MUL12: begin
                mul_a = $signed({{(MW-LEN_W){1'b0}}, r_lower});
                mul_b = $signed({{(MW-SQ_RW){1'b0}}, r_hq});
            end
            OP_AC_SQR: begin mul_a = MW'(r_r); mul_b = MW'(r_r); end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sums around the multiplier
    logic signed [AW-1:0] prod_n, sum_xr, sum_yr;
    logic signed [20:0]   xr_sh, yr_sh;

    assign prod_n = r_prod[AW-1:0];
    assign sum_xr = r_acc - prod_n + AW'(32768);
    assign sum_yr = r_acc + prod_n + AW'(32768);
    assign xr_sh  = 21'(sum_xr >>> 16);
    assign yr_sh  = 21'(sum_yr >>> 16);

    // acos argument selection and range check
    logic signed [35:0] num_sel, num_neg;
    logic [40:0]        den_sel;
    logic [34:0]        mag;
    logic               need_div;

    assign num_sel  = i_cmd.sel ? r_num2 : r_num1;
    assign den_sel  = i_cmd.sel ? r_den2 : r_den1;
    assign num_neg  = -num_sel;
    assign mag      = num_sel[35] ? num_neg[34:0] : num_sel[34:0];
    assign need_div = (den_sel != '0) && ({mag, 8'b0} <= {2'b00, den_sel});

    // restoring divider, one quotient bit per cycle
    logic [58:0] r_rem, dsh_ext;
    logic [56:0] r_dsh;
    logic [16:0] r_q;
    logic [4:0]  r_dcnt;
    logic        r_dv_busy;
    logic        dv_ge;

    assign dsh_ext = {2'b00, r_dsh};
    assign dv_ge   = (r_rem >= dsh_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dcnt    <= '0;
        end else if (i_cmd.op == OP_DV_GO) begin
            r_dv_busy <= 1'b1;
            r_dcnt    <= 5'd16;
        end else if (r_dv_busy) begin
            if (r_dcnt == '0) begin
                r_dv_busy <= 1'b0;
            end else begin
                r_dcnt <= r_dcnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DV_GO) begin
            r_rem <= {mag, 24'b0};
            r_dsh <= {den_sel, 16'b0};
            r_q   <= '0;
        end else if (r_dv_busy) begin
            if (dv_ge) r_rem <= r_rem - dsh_ext;
            r_q   <= {r_q[15:0], dv_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    // shared square root unit
    logic              sq_start, sq_busy;
    logic [SQ_W-1:0]   sq_arg;
    logic [SQ_RW-1:0]  sq_root;
    logic [32:0]       one_minus_r2;

    assign one_minus_r2 = 33'h1_0000_0000 - r_prod[32:0];

    always_comb begin
        sq_start = 1'b0;
        sq_arg   = '0;
        unique case (i_cmd.op)
            OP_SQL_GO: begin sq_start = 1'b1; sq_arg = {1'b0, r_l2, 16'b0}; end
            OP_SQH_GO: begin sq_start = 1'b1; sq_arg = {1'b0, r_h2, 16'b0}; end
            OP_ASQ_GO: begin
                sq_start = 1'b1;
                sq_arg   = {{(SQ_W-33){1'b0}}, one_minus_r2};
            end
            default: ;
        endcase
    end

    lik_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_arg   (sq_arg),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // shared angle unit
    logic                 cd_start, cd_busy;
    logic signed [CW-1:0] cd_y, cd_x;
    logic signed [ZW-1:0] cd_angle;

    always_comb begin
        cd_start = 1'b0;
        cd_y     = '0;
        cd_x     = '0;
        unique case (i_cmd.op)
            OP_CB_GO: begin
                cd_start = 1'b1;
                cd_y     = CW'($signed({r_yr, 8'b0}));
                cd_x     = CW'($signed({r_xr, 8'b0}));
            end
            OP_CP_GO: begin
                cd_start = 1'b1;
                cd_y     = CW'($signed({r_zr, 8'b0}));
                cd_x     = $signed({{(CW-SQ_RW){1'b0}}, r_lq});
            end
            OP_ACD_GO: begin
                cd_start = 1'b1;
                cd_y     = $signed({{(CW-17){1'b0}}, r_sroot});
                cd_x     = CW'(r_r);
            end
            default: ;
        endcase
    end

    lik_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_y     (cd_y),
        .i_x     (cd_x),
        .o_busy  (cd_busy),
        .o_angle (cd_angle)
    );

    // rounding of angles to degrees times 128
    logic signed [ZW-1:0] base_rnd;
    logic signed [ZW:0]   hip_sum, knee_sum, hip_rnd, knee_rnd;
    logic signed [16:0]   base_out;

    assign base_rnd = (cd_angle + ZW'(256)) >>> 9;
    assign base_out = 17'(base_rnd);
    assign hip_sum  = (ZW+1)'(r_phi) + (ZW+1)'(r_theta) + (ZW+1)'(256);
    assign knee_sum = -(ZW+1)'(r_theta) - (ZW+1)'(r_gamma) + (ZW+1)'(256);
    assign hip_rnd  = hip_sum >>> 9;
    assign knee_rnd = knee_sum >>> 9;

    // step registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op != OP_NONE && i_cmd.op != OP_LOAD) r_prod <= mul_p;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x   <= i_target_x;
                r_y   <= i_target_y;
                r_zr  <= 17'(i_target_z) + 17'(r_offz);
                r_c   <= rot_cos(r_cur_leg);
                r_s   <= rot_sin(r_cur_leg);
                r_leg <= r_cur_leg;
            end
            OP_MUL2:  r_acc <= prod_n;
            OP_MUL3:  r_xr  <= 18'(xr_sh + 21'(r_offx));
            OP_MUL4:  r_acc <= prod_n;
            OP_MUL5:  r_yr  <= 18'(yr_sh);
            OP_MUL6:  r_acc <= prod_n;
            OP_MUL7:  r_l2  <= 35'(r_acc + prod_n);
            OP_MUL8:  r_h2  <= r_l2 + r_prod[34:0];
            OP_MUL9:  r_acc <= prod_n;
            OP_MUL10: begin
                r_num1 <= 36'($signed({2'b00, r_h2}) + r_acc - prod_n);
                r_num2 <= 36'($signed({2'b00, r_h2}) - r_acc + prod_n);
            end
            OP_SQL_WT: if (!sq_busy) r_lq <= sq_root;
            OP_SQH_WT: if (!sq_busy) r_hq <= sq_root;
            OP_MUL12:  r_den1 <= {r_prod[39:0], 1'b0};
            OP_MUL13:  r_den2 <= {r_prod[39:0], 1'b0};
            OP_CB_WT: begin
                if (!cd_busy) begin
                    if (base_out > 17'sd23040) r_base <= 16'sd23040;
                    else if (base_out < -17'sd23040) r_base <= -16'sd23040;
                    else r_base <= base_out[15:0];
                end
            end
            OP_CP_WT: if (!cd_busy) r_phi <= cd_angle;
            OP_AC_CHK: if (!need_div) r_r <= num_sel[35] ? -18'sd65536 : 18'sd65536;
            OP_DV_WT: begin
                if (!r_dv_busy) r_r <= num_sel[35] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
            end
            OP_ASQ_WT: if (!sq_busy) r_sroot <= sq_root[16:0];
            OP_ACD_WT: begin
                if (!cd_busy) begin
                    if (i_cmd.sel) r_gamma <= cd_angle;
                    else r_theta <= cd_angle;
                end
            end
            OP_FIN: begin
                r_hip  <= 18'(hip_rnd);
                r_knee <= 18'(knee_rnd);
            end
            default: ;
        endcase
    end

    // reach flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b1;
        end else if (i_cmd.op == OP_LOAD) begin
            r_ok <= 1'b1;
        end else if (i_cmd.op == OP_AC_CHK && !need_div) begin
            r_ok <= 1'b0;
        end
    end

    // result register
    logic r_out_valid;
    logic signed [18:0] hip_servo, knee_servo;

    assign hip_servo  = 19'(r_rest_hip) - 19'(r_hip);
    assign knee_servo = 19'(r_knee) - 19'(r_rest_knee);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            o_leg_number       <= r_leg;
            o_base_angle       <= r_base;
            o_hip_angle        <= r_hip[16:0];
            o_knee_angle       <= r_knee[16:0];
            o_hip_servo_angle  <= hip_servo[17:0];
            o_knee_servo_angle <= knee_servo[17:0];
            o_reachable        <= r_ok;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.busy     = sq_busy | cd_busy | r_dv_busy;
    assign o_status.need_div = need_div;
    assign o_status.out_full = r_out_valid;

endmodule

@@ rtl/two_link_leg_inverse_kinematics_top.sv @@
// top level of the six-leg two-link inverse kinematics solver
//
//  channel   direction  handshake                 beat carries
//  in        upstream   i_in_valid / o_in_stall   target x, y, z
//  out       down       o_out_valid / i_out_stall leg, angles, servo angles, reachable
//  cfg       host       i_cfg_valid / o_cfg_ready register index and data
//
// one item at a time, the time per item set by the shared bit-serial square
// root (used four times), the shared cordic (used four times) and the divider
// (twice, skipped out of reach).
// reset is synchronous, active low; it loads the register defaults and leg 1.
// a finished result waits in the output register while the next item is taken;
// a stalled output holds the solver before its final step.
module two_link_leg_inverse_kinematics_top #(
    parameter int CORDIC_ITERATIONS = lik_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [lik_pkg::POS_W-1:0] i_target_x,
    input  logic signed [lik_pkg::POS_W-1:0] i_target_y,
    input  logic signed [lik_pkg::POS_W-1:0] i_target_z,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_leg_number,
    output logic signed [15:0]               o_base_angle,
    output logic signed [16:0]               o_hip_angle,
    output logic signed [16:0]               o_knee_angle,
    output logic signed [17:0]               o_hip_servo_angle,
    output logic signed [17:0]               o_knee_servo_angle,
    output logic                             o_reachable,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lik_pkg::CIDX_W-1:0]       i_cfg_index,
    input  logic [lik_pkg::CDAT_W-1:0]       i_cfg_data
);
    import lik_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    lik_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // arithmetic
    lik_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_target_x         (i_target_x),
        .i_target_y         (i_target_y),
        .i_target_z         (i_target_z),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_leg_number       (o_leg_number),
        .o_base_angle       (o_base_angle),
        .o_hip_angle        (o_hip_angle),
        .o_knee_angle       (o_knee_angle),
        .o_hip_servo_angle  (o_hip_servo_angle),
        .o_knee_servo_angle (o_knee_servo_angle),
        .o_reachable        (o_reachable)
    );

endmodule
